>>> rtl/core/cmap4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmap4_pkg
// Shared types and constants for the cmap format 4 glyph lookup core.
// ---------------------------------------------------------------------------
package cmap4_pkg;

  localparam int MaxSegments   = 256;
  localparam int MaxGlyphWords = 4096;
  localparam int SegAddrW      = $clog2(MaxSegments);
  localparam int GlyphAddrW    = $clog2(MaxGlyphWords);
  localparam int SegCntW       = 9;
  localparam int GlyphCntW     = 13;
  localparam int CfgDataW      = 13;
  localparam int SlotW         = 12;
  localparam int CodeW         = 16;
  localparam int CpW           = 21;

  typedef enum logic [1:0] {
    KIND_SEG    = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_MAPPED       = 3'd0,
    STAT_NO_SEGMENT   = 3'd1,
    STAT_BELOW_START  = 3'd2,
    STAT_OUT_OF_RANGE = 3'd3,
    STAT_ARRAY_ZERO   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_SEG_COUNT   = 1'b0,
    CFG_GLYPH_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SEG,
    ST_FETCH,
    ST_IDX,
    ST_RANGE,
    ST_WORD
  } state_e;

  typedef struct packed {
    logic [CodeW-1:0] end_code;
    logic [CodeW-1:0] start_cp;
    logic [CodeW-1:0] delta;
    logic [CodeW-1:0] roff;
  } seg_entry_t;

  typedef struct packed {
    logic                we;
    logic [SegAddrW-1:0] addr;
    seg_entry_t          wdata;
  } seg_ram_req_t;

  typedef struct packed {
    logic                  we;
    logic [GlyphAddrW-1:0] addr;
    logic [CodeW-1:0]      wdata;
  } glyph_ram_req_t;

endpackage
`default_nettype wire

>>> rtl/core/cmap4_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmap4 channel interfaces
// Request channel (loads and lookups) and response channel (glyph, status).
// ---------------------------------------------------------------------------
interface cmap4_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic [cmap4_pkg::SlotW-1:0]      slot;
  logic [cmap4_pkg::CodeW-1:0]      seg_end;
  logic [cmap4_pkg::CodeW-1:0]      seg_start;
  logic signed [cmap4_pkg::CodeW-1:0] seg_delta;
  logic [cmap4_pkg::CodeW-1:0]      seg_range_offset;
  logic [cmap4_pkg::CodeW-1:0]      array_word;
  logic [cmap4_pkg::CpW-1:0]        codepoint;

  modport source (output valid, kind, slot, seg_end, seg_start, seg_delta,
                  seg_range_offset, array_word, codepoint, input ready);
  modport sink (input valid, kind, slot, seg_end, seg_start, seg_delta,
                seg_range_offset, array_word, codepoint, output ready);
endinterface

interface cmap4_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cmap4_pkg::CodeW-1:0] glyph;
  logic [2:0]                  status;

  modport source (output valid, glyph, status, input ready);
  modport sink (input valid, glyph, status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cmap4_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmap4_ram
// Single-port RAM, one write or read address per cycle, registered read data.
// ---------------------------------------------------------------------------
module cmap4_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/cmap4_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmap4_seq
// Sequencer: binary search over the segment RAM, then segment check and glyph
// array access, one add/compare step per cycle unless the response stalls.
// ---------------------------------------------------------------------------
module cmap4_seq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [cmap4_pkg::SegCntW-1:0]     seg_used_i,
  input  wire logic [cmap4_pkg::GlyphCntW-1:0]   word_used_i,
  cmap4_req_if.sink                              req_i,
  cmap4_rsp_if.source                            rsp_o,
  output cmap4_pkg::seg_ram_req_t                seg_req_o,
  input  wire cmap4_pkg::seg_entry_t             seg_rdata_i,
  output cmap4_pkg::glyph_ram_req_t              glyph_req_o,
  input  wire logic [cmap4_pkg::CodeW-1:0]       glyph_rdata_i
);

  localparam int CW = cmap4_pkg::CodeW;
  localparam int NW = cmap4_pkg::SegCntW;

  cmap4_pkg::state_e state_q, state_d;
  logic [cmap4_pkg::CpW-1:0]      cp_q, cp_d;
  logic [NW-1:0]                  lo_q, lo_d;
  logic [NW-1:0]                  n_q, n_d;
  logic [cmap4_pkg::SegAddrW-1:0] h_q, h_d;
  logic [CW-1:0]                  t_q, t_d;
  logic [CW-1:0]                  idx_q, idx_d;
  logic [CW-1:0]                  delta_q, delta_d;
  logic                           out_valid_q, out_valid_d;
  logic [CW-1:0]                  glyph_q, glyph_d;
  logic [2:0]                     status_q, status_d;

  logic                           accept;
  logic                           can_emit;
  logic                           finish;
  logic [CW-1:0]                  res_glyph;
  cmap4_pkg::status_e             res_status;
  logic [CW-1:0]                  cp16;

  assign req_i.ready = (state_q == cmap4_pkg::ST_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign can_emit = !out_valid_q || rsp_o.ready;
  assign cp16     = cp_q[CW-1:0];

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.glyph  = glyph_q;
  assign rsp_o.status = status_q;

  always_comb begin
    state_d    = state_q;
    cp_d       = cp_q;
    lo_d       = lo_q;
    n_d        = n_q;
    h_d        = h_q;
    t_d        = t_q;
    idx_d      = idx_q;
    delta_d    = delta_q;
    finish     = 1'b0;
    res_glyph  = '0;
    res_status = cmap4_pkg::STAT_MAPPED;

    seg_req_o.we     = 1'b0;
    seg_req_o.addr   = lo_q[cmap4_pkg::SegAddrW-1:0];
    seg_req_o.wdata  = {req_i.seg_end, req_i.seg_start, req_i.seg_delta,
                        req_i.seg_range_offset};
    glyph_req_o.we    = 1'b0;
    glyph_req_o.addr  = idx_q[cmap4_pkg::GlyphAddrW-1:0];
    glyph_req_o.wdata = req_i.array_word;

    case (state_q)
      cmap4_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            cmap4_pkg::KIND_SEG: begin
              seg_req_o.we   = (req_i.slot < cmap4_pkg::SlotW'(cmap4_pkg::MaxSegments));
              seg_req_o.addr = req_i.slot[cmap4_pkg::SegAddrW-1:0];
            end
            cmap4_pkg::KIND_WORD: begin
              glyph_req_o.we   = 1'b1;
              glyph_req_o.addr = req_i.slot[cmap4_pkg::GlyphAddrW-1:0];
            end
            cmap4_pkg::KIND_LOOKUP: begin
              cp_d    = req_i.codepoint;
              lo_d    = '0;
              n_d     = seg_used_i;
              state_d = cmap4_pkg::ST_PROBE;
            end
            default: ;
          endcase
        end
      end
      cmap4_pkg::ST_PROBE: begin
        if (n_q == '0) begin
          state_d = cmap4_pkg::ST_SEG;
        end else begin
          h_d            = n_q[NW-1:1];
          seg_req_o.addr = cmap4_pkg::SegAddrW'(lo_q + {1'b0, n_q[NW-1:1]});
          state_d        = cmap4_pkg::ST_CMP;
        end
      end
      cmap4_pkg::ST_CMP: begin
        // end code below codepoint: search moves past the probe
        if (cmap4_pkg::CpW'(seg_rdata_i.end_code) < cp_q) begin
          lo_d = lo_q + NW'(h_q) + NW'(1);
          n_d  = n_q - NW'(h_q) - NW'(1);
        end else begin
          n_d = NW'(h_q);
        end
        state_d = cmap4_pkg::ST_PROBE;
      end
      cmap4_pkg::ST_SEG: begin
        if (lo_q >= seg_used_i) begin
          finish     = 1'b1;
          res_status = cmap4_pkg::STAT_NO_SEGMENT;
        end else begin
          state_d = cmap4_pkg::ST_FETCH;
        end
      end
      cmap4_pkg::ST_FETCH: begin
        // a segment was found, so the codepoint fits in 16 bits
        delta_d = seg_rdata_i.delta;
        t_d     = {1'b0, seg_rdata_i.roff[CW-1:1]} + cp16
                  - seg_rdata_i.start_cp;
        if (seg_rdata_i.start_cp > cp16) begin
          finish     = 1'b1;
          res_status = cmap4_pkg::STAT_BELOW_START;
        end else if (seg_rdata_i.roff == '0) begin
          finish    = 1'b1;
          res_glyph = cp16 + seg_rdata_i.delta;
        end else begin
          state_d = cmap4_pkg::ST_IDX;
        end
      end
      cmap4_pkg::ST_IDX: begin
        idx_d   = t_q - (CW'(seg_used_i) - CW'(lo_q));
        state_d = cmap4_pkg::ST_RANGE;
      end
      cmap4_pkg::ST_RANGE: begin
        if (idx_q >= CW'(word_used_i)) begin
          finish     = 1'b1;
          res_status = cmap4_pkg::STAT_OUT_OF_RANGE;
        end else begin
          state_d = cmap4_pkg::ST_WORD;
        end
      end
      cmap4_pkg::ST_WORD: begin
        finish = 1'b1;
        if (glyph_rdata_i == '0) begin
          res_status = cmap4_pkg::STAT_ARRAY_ZERO;
        end else begin
          res_glyph = glyph_rdata_i + delta_q;
        end
      end
      default: state_d = cmap4_pkg::ST_IDLE;
    endcase

    // hold the finishing state until the output register is free
    out_valid_d = out_valid_q && !rsp_o.ready;
    glyph_d     = glyph_q;
    status_d    = status_q;
    if (finish) begin
      if (can_emit) begin
        out_valid_d = 1'b1;
        glyph_d     = res_glyph;
        status_d    = res_status;
        state_d     = cmap4_pkg::ST_IDLE;
      end else begin
        state_d = state_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmap4_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q     <= cp_d;
    lo_q     <= lo_d;
    n_q      <= n_d;
    h_q      <= h_d;
    t_q      <= t_d;
    idx_q    <= idx_d;
    delta_q  <= delta_d;
    glyph_q  <= glyph_d;
    status_q <= status_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/cmap_format4_glyph_lookup_core.sv
// a load transaction is written to its RAM as it is accepted; a lookup runs
// ceil(log2(segment_count + 1)) binary search steps, at most 9, each a probe
// and a compare, then the segment check and the glyph array read
// the next transaction is accepted once the response is registered, even
// while it waits; a stalled response holds the lookup in its last state
// reset clears control state and both count registers; RAMs undefined until loaded
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmap_format4_glyph_lookup_core
// Character-to-glyph mapping for cmap format 4 tables held in on-chip RAM.
// ---------------------------------------------------------------------------
module cmap_format4_glyph_lookup_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [0:0]                       cfg_idx_i,
  input  wire logic [cmap4_pkg::CfgDataW-1:0]   cfg_wdata_i,
  cmap4_req_if.sink                             req_i,
  cmap4_rsp_if.source                           rsp_o
);

  logic [cmap4_pkg::SegCntW-1:0]   seg_num_q;
  logic [cmap4_pkg::GlyphCntW-1:0] word_count_q;
  logic [cmap4_pkg::SegCntW-1:0]   seg_used;
  logic [cmap4_pkg::GlyphCntW-1:0] word_used;

  cmap4_pkg::seg_ram_req_t   seg_req;
  cmap4_pkg::glyph_ram_req_t glyph_req;
  logic [$bits(cmap4_pkg::seg_entry_t)-1:0] seg_rdata_raw;
  logic [cmap4_pkg::CodeW-1:0]              glyph_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_num_q    <= '0;
      word_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cmap4_pkg::CFG_SEG_COUNT) begin
        seg_num_q <= cfg_wdata_i[cmap4_pkg::SegCntW-1:0];
      end else begin
        word_count_q <= cfg_wdata_i[cmap4_pkg::GlyphCntW-1:0];
      end
    end
  end

  // oversized counts saturate at the table depth
  assign seg_used  = (seg_num_q > cmap4_pkg::SegCntW'(cmap4_pkg::MaxSegments))
                   ? cmap4_pkg::SegCntW'(cmap4_pkg::MaxSegments) : seg_num_q;
  assign word_used = (word_count_q > cmap4_pkg::GlyphCntW'(cmap4_pkg::MaxGlyphWords))
                   ? cmap4_pkg::GlyphCntW'(cmap4_pkg::MaxGlyphWords) : word_count_q;

  cmap4_ram #(
    .Width ($bits(cmap4_pkg::seg_entry_t)),
    .Depth (cmap4_pkg::MaxSegments)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_req.we),
    .addr_i  (seg_req.addr),
    .wdata_i (seg_req.wdata),
    .rdata_o (seg_rdata_raw)
  );

  cmap4_ram #(
    .Width (cmap4_pkg::CodeW),
    .Depth (cmap4_pkg::MaxGlyphWords)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_req.we),
    .addr_i  (glyph_req.addr),
    .wdata_i (glyph_req.wdata),
    .rdata_o (glyph_rdata)
  );

  cmap4_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seg_used_i    (seg_used),
    .word_used_i   (word_used),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .seg_req_o     (seg_req),
    .seg_rdata_i   (cmap4_pkg::seg_entry_t'(seg_rdata_raw)),
    .glyph_req_o   (glyph_req),
    .glyph_rdata_i (glyph_rdata)
  );

endmodule
`default_nettype wire
